// ===== rtl/core/vat_pkg.sv =====
// Package for the vertex affine transform: register indexes, mode codes,
// per-lane operation codes, datapath widths and the 32-bit saturation helper.
// No dependencies.
`default_nettype none

package vat_pkg;

  // Coordinate and register widths.
  localparam int unsigned COORD_W = 32;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned COEF_W  = 24;
  localparam int unsigned AXIS_W  = 2;
  localparam int unsigned TRIG_W  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned LANES   = 3;
  localparam int unsigned LANE_W  = 2;

  // Product and accumulator widths.
  localparam int unsigned P0_W  = COEF_W + COORD_W;  // coefficient times coordinate
  localparam int unsigned P1_W  = TRIG_W + COORD_W;  // sine times partner coordinate
  localparam int unsigned ACC_W = P0_W + 2;

  // Fraction bits dropped after each kind of product.
  localparam int unsigned SCALE_FRAC = 16;
  localparam int unsigned TRIG_FRAC  = 14;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_COEF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AXIS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COS_VALUE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_VALUE    = 3'd5;

  // Mode codes.
  localparam logic [MODE_W-1:0] MODE_SCALE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SHIFT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ROT_X = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ROT_Y = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ROT_Z = 3'd4;

  // Reset values of the registers.
  localparam logic [MODE_W-1:0] MODE_RESET  = MODE_SCALE;
  localparam logic [COEF_W-1:0] COEF_RESET  = 24'h01_0000;
  localparam logic [TRIG_W-1:0] COS_RESET   = 16'h4000;
  localparam logic [TRIG_W-1:0] SIN_RESET   = 16'h0000;

  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7fff_ffff;
  localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

  // What one coordinate lane does to its value.
  typedef enum logic [1:0] {
    OP_PASS,
    OP_SCALE,
    OP_ADD,
    OP_ROT
  } lane_op_t;

  // One lane between the product register and the result register.
  typedef struct packed {
    lane_op_t                   op;
    logic                       neg;
    logic signed [COORD_W-1:0]  v;
    logic signed [P0_W-1:0]     p0;
    logic signed [P1_W-1:0]     p1;
  } lane_t;

  typedef struct packed {
    logic [COORD_W-1:0] value;
    logic               ovf;
  } sat_t;

  // Clamp a wide signed value to 32 bits and flag the clamp.
  function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
    sat_t r;
    if (v[ACC_W-1:COORD_W-1] == {(ACC_W-COORD_W+1){1'b0}} ||
        v[ACC_W-1:COORD_W-1] == {(ACC_W-COORD_W+1){1'b1}}) begin
      r.value = v[COORD_W-1:0];
      r.ovf   = 1'b0;
    end else begin
      r.value = v[ACC_W-1] ? COORD_MIN : COORD_MAX;
      r.ovf   = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vertex_affine_transform.sv =====
// Top level of the vertex affine transform: a three-register pipeline that scales,
// shifts or rotates one Q16.16 vertex per clock while the output is ready. Depends on vat_pkg.
`default_nettype none

// The block takes one vertex request per clock on the slave stream and returns one
// transformed vertex request per clock on the master stream while the master side is
// ready. An accepted request passes through the input, product and result registers in
// turn before it is offered on the master side, and results leave with no gaps while
// the master side is ready. The full rate comes from the three coordinate lanes, each
// with its own coefficient multiplier and sine multiplier, working in parallel between
// the input register and the product register; the rounding, the exact sum of the two
// rotation products and the 32-bit saturation happen between the product register and
// the result register. Each stage holds a valid bit and loads whenever it is empty or
// the stage after it moves, so a stalled output leaves earlier bubbles free to fill and
// a new request is taken while a finished vertex waits, as long as an earlier stage is
// empty. The mode and coefficient registers are sampled while a vertex is in flight,
// so they are to be written only while the pipeline is empty.
// Unused modes and a shift axis of three pass the vertex unchanged with no overflow.
module vertex_affine_transform (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Configuration write port.
  input  wire logic                             cfg_we,
  input  wire logic [vat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [vat_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // Slave stream: vertex in.
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [3*vat_pkg::COORD_W-1:0]    s_tdata,  // in_x, in_y, in_z
  input  wire logic                             s_tlast,  // in_last
  // Master stream: vertex out.
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [3*vat_pkg::COORD_W-1:0]         m_tdata,  // out_x, out_y, out_z
  output logic                                  m_tuser,  // out_overflow
  output logic                                  m_tlast   // out_last
);
  import vat_pkg::*;

  localparam logic signed [ACC_W-1:0] RND_SCALE = ACC_W'(1 << (SCALE_FRAC - 1));
  localparam logic signed [ACC_W-1:0] RND_TRIG  = ACC_W'(1 << (TRIG_FRAC - 1));

  // Configuration registers.
  logic [MODE_W-1:0]          mode;
  logic signed [COEF_W-1:0]   scale_coef;
  logic signed [COORD_W-1:0]  shift_amount;
  logic [AXIS_W-1:0]          shift_axis;
  logic signed [TRIG_W-1:0]   cos_value;
  logic signed [TRIG_W-1:0]   sin_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_RESET;
      scale_coef   <= COEF_RESET;
      shift_amount <= '0;
      shift_axis   <= '0;
      cos_value    <= COS_RESET;
      sin_value    <= SIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:         mode         <= cfg_wdata[MODE_W-1:0];
        REG_SCALE_COEF:   scale_coef   <= cfg_wdata[COEF_W-1:0];
        REG_SHIFT_AMOUNT: shift_amount <= cfg_wdata[COORD_W-1:0];
        REG_SHIFT_AXIS:   shift_axis   <= cfg_wdata[AXIS_W-1:0];
        REG_COS_VALUE:    cos_value    <= cfg_wdata[TRIG_W-1:0];
        REG_SIN_VALUE:    sin_value    <= cfg_wdata[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and the moves between stages. A stage loads when it is empty
  // or when the stage after it is moving on.
  logic in_valid;
  logic prod_valid;
  logic en_in;
  logic en_prod;
  logic en_out;

  assign en_out   = !m_tvalid || m_tready;
  assign en_prod  = !prod_valid || en_out;
  assign en_in    = !in_valid || en_prod;
  assign s_tready = en_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      prod_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (en_in)   in_valid   <= s_tvalid;
      if (en_prod) prod_valid <= in_valid;
      if (en_out)  m_tvalid   <= prod_valid;
    end
  end

  // Input register.
  logic signed [COORD_W-1:0] in_v [LANES];
  logic                      in_last;

  always_ff @(posedge clk) begin
    if (en_in) begin
      for (int i = 0; i < LANES; i++) begin
        in_v[i] <= s_tdata[i*COORD_W +: COORD_W];
      end
      in_last <= s_tlast;
    end
  end

  // Lane decode and products. For a rotation the first lane of the pair gets
  // C*a + S*b and the second gets C*b - S*a; the subtraction is done after the
  // product register, so only the flag travels here.
  logic                       rot_en;
  logic [LANE_W-1:0]          rot_a;
  logic [LANE_W-1:0]          rot_b;
  logic signed [COEF_W-1:0]   mult0;
  lane_t                      lane_next [LANES];
  lane_t                      lane      [LANES];
  logic                       prod_last;

  always_comb begin
    rot_en = 1'b0;
    rot_a  = LANE_W'(0);
    rot_b  = LANE_W'(1);
    case (mode)
      MODE_ROT_X: begin
        rot_en = 1'b1;
        rot_a  = LANE_W'(1);
        rot_b  = LANE_W'(2);
      end
      MODE_ROT_Y: begin
        rot_en = 1'b1;
        rot_a  = LANE_W'(0);
        rot_b  = LANE_W'(2);
      end
      MODE_ROT_Z: begin
        rot_en = 1'b1;
        rot_a  = LANE_W'(0);
        rot_b  = LANE_W'(1);
      end
      default: ;
    endcase
    mult0 = (mode == MODE_SCALE) ? scale_coef : COEF_W'(cos_value);
  end

  always_comb begin
    logic [LANE_W-1:0] partner;
    for (int i = 0; i < LANES; i++) begin
      lane_next[i].op  = OP_PASS;
      lane_next[i].neg = 1'b0;
      partner          = rot_b;
      if (mode == MODE_SCALE) begin
        lane_next[i].op = OP_SCALE;
      end else if (mode == MODE_SHIFT) begin
        if ({1'b0, shift_axis} == 3'(i)) lane_next[i].op = OP_ADD;
      end else if (rot_en) begin
        if (rot_a == LANE_W'(i)) begin
          lane_next[i].op = OP_ROT;
          partner         = rot_b;
        end else if (rot_b == LANE_W'(i)) begin
          lane_next[i].op  = OP_ROT;
          lane_next[i].neg = 1'b1;
          partner          = rot_a;
        end
      end
      lane_next[i].v  = in_v[i];
      lane_next[i].p0 = P0_W'(mult0 * in_v[i]);
      lane_next[i].p1 = P1_W'(sin_value * in_v[partner]);
    end
  end

  // Product register.
  always_ff @(posedge clk) begin
    if (en_prod) begin
      for (int i = 0; i < LANES; i++) begin
        lane[i] <= lane_next[i];
      end
      prod_last <= in_last;
    end
  end

  // Sum, round (add half, floor) and saturate.
  sat_t res [LANES];
  logic ovf_any;

  always_comb begin
    logic signed [ACC_W-1:0] e0;
    logic signed [ACC_W-1:0] e1;
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] r;
    ovf_any = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      e0 = {{(ACC_W-P0_W){lane[i].p0[P0_W-1]}}, lane[i].p0};
      e1 = {{(ACC_W-P1_W){lane[i].p1[P1_W-1]}}, lane[i].p1};
      if (lane[i].neg) e1 = -e1;
      case (lane[i].op)
        OP_SCALE: begin
          t = e0 + RND_SCALE;
          r = t >>> SCALE_FRAC;
        end
        OP_ROT: begin
          t = e0 + e1 + RND_TRIG;
          r = t >>> TRIG_FRAC;
        end
        OP_ADD: begin
          t = {{(ACC_W-COORD_W){lane[i].v[COORD_W-1]}}, lane[i].v};
          r = t + {{(ACC_W-COORD_W){shift_amount[COORD_W-1]}}, shift_amount};
        end
        default: begin
          t = {{(ACC_W-COORD_W){lane[i].v[COORD_W-1]}}, lane[i].v};
          r = t;
        end
      endcase
      res[i]  = sat32(r);
      ovf_any = ovf_any | res[i].ovf;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (en_out) begin
      for (int i = 0; i < LANES; i++) begin
        m_tdata[i*COORD_W +: COORD_W] <= res[i].value;
      end
      m_tuser <= ovf_any;
      m_tlast <= prod_last;
    end
  end

  // A drained slot behind the output leaves the output empty after it moves.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !prod_valid) |=> !m_tvalid)
    else $error("output stayed valid with no vertex behind it");

  // A flagged vertex carries at least one clamped coordinate.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      (m_tdata[31:0] == COORD_MAX || m_tdata[31:0] == COORD_MIN ||
       m_tdata[63:32] == COORD_MAX || m_tdata[63:32] == COORD_MIN ||
       m_tdata[95:64] == COORD_MAX || m_tdata[95:64] == COORD_MIN))
    else $error("overflow flag without a saturated coordinate");

  // A vertex whose lanes all pass through cannot overflow.
  assert property (@(posedge clk) disable iff (rst)
    (en_out && prod_valid && lane[0].op == OP_PASS && lane[1].op == OP_PASS &&
     lane[2].op == OP_PASS) |=> !m_tuser)
    else $error("overflow flagged on a pass-through vertex");

  // Reset empties the pipeline.
  assert property (@(posedge clk) $past(rst) |-> (!m_tvalid && !in_valid && !prod_valid))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
